// ===== design/ntis_pkg.sv =====
// ----------------------------------------------------------------------------
// ntis_pkg: shared types and codes of the name table core
// Operation and status codes, result field widths and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ntis_pkg;

    // Field widths of the item and the result
    localparam int FuncW   = 2;
    localparam int HeadW   = 64;
    localparam int TailW   = 8;
    localparam int StatusW = 2;
    localparam int SlotW   = 4;
    localparam int OccW    = 5;
    localparam int EntryW  = HeadW + TailW;

    // Largest number of results that one list item emits
    localparam int ListCap = 16;

    // Operation codes
    localparam logic [FuncW-1:0] FnCreate = 2'd0;
    localparam logic [FuncW-1:0] FnDelete = 2'd1;
    localparam logic [FuncW-1:0] FnSearch = 2'd2;
    localparam logic [FuncW-1:0] FnList   = 2'd3;

    // Result status codes
    localparam logic [StatusW-1:0] StsOk       = 2'd0;
    localparam logic [StatusW-1:0] StsNotFound = 2'd1;
    localparam logic [StatusW-1:0] StsFull     = 2'd2;
    localparam logic [StatusW-1:0] StsEmpty    = 2'd3;

    // Source of the slot field of a result
    localparam logic [1:0] SlotZero  = 2'd0;
    localparam logic [1:0] SlotIdx   = 2'd1;
    localparam logic [1:0] SlotCount = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic               load;      // capture key of a new item
        logic               idx_clr;   // restart the walk index
        logic               idx_inc;   // step the walk index
        logic               rd_en;     // read the entry RAM
        logic               rd_last;   // read the last entry, not the indexed one
        logic               wr_en;     // write the entry RAM
        logic               wr_move;   // move read data to the indexed slot
        logic               cnt_inc;   // grow the table
        logic               cnt_dec;   // shrink the table
        logic               emit;      // load the result register
        logic [StatusW-1:0] status;
        logic [1:0]         slot_sel;
        logic               data_sel;  // show read entry in the result
        logic               last;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;       // count has reached the table size
        logic empty;      // count is zero
        logic at_end;     // walk index equals the count
        logic match;      // read entry equals the key
        logic list_last;  // walk index is the final listed entry
    } t_stat;

endpackage

`default_nettype wire

// ===== design/ntis_ram.sv =====
// ----------------------------------------------------------------------------
// ntis_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_ram #(
    parameter int Width = 72,
    parameter int Depth = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_wr_addr,
    input  wire logic [Width-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_rd_addr,
    output      logic [Width-1:0]                     o_rd_data
);

    logic [Width-1:0] r_mem [Depth];

    // Write, then register read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ntis_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntis_ctrl: operation sequencer of the name table core
// Decodes each item and steps the datapath through append, scan, move
// and list sequences, at most one RAM access per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ntis_pkg::FuncW-1:0] i_func,
    input  wire ntis_pkg::t_stat           i_stat,
    output      ntis_pkg::t_cmd            o_cmd,
    output      logic                      o_busy
);

    localparam logic [2:0] StIdle    = 3'd0;
    localparam logic [2:0] StCreate  = 3'd1;
    localparam logic [2:0] StScanRd  = 3'd2;
    localparam logic [2:0] StScanCmp = 3'd3;
    localparam logic [2:0] StDelRd   = 3'd4;
    localparam logic [2:0] StDelWr   = 3'd5;
    localparam logic [2:0] StListRd  = 3'd6;
    localparam logic [2:0] StListOut = 3'd7;

    logic [2:0]                 r_state, n_state;
    logic [ntis_pkg::FuncW-1:0] r_func, n_func;

    // Sequence the current operation
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_func  = r_func;
        unique case (r_state)
            StIdle: begin
                if (i_start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_func        = i_func;
                    unique case (i_func) inside
                        ntis_pkg::FnCreate:                     n_state = StCreate;
                        ntis_pkg::FnDelete, ntis_pkg::FnSearch: n_state = StScanRd;
                        default:                                n_state = StListRd;
                    endcase
                end
            end
            StCreate: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = 1'b1;
                if (i_stat.full) begin
                    o_cmd.status   = ntis_pkg::StsFull;
                    o_cmd.slot_sel = ntis_pkg::SlotZero;
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.status   = ntis_pkg::StsOk;
                    o_cmd.slot_sel = ntis_pkg::SlotCount;
                end
                n_state = StIdle;
            end
            StScanRd: begin
                if (i_stat.at_end) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.last     = 1'b1;
                    o_cmd.status   = ntis_pkg::StsNotFound;
                    o_cmd.slot_sel = ntis_pkg::SlotZero;
                    n_state        = StIdle;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = StScanCmp;
                end
            end
            StScanCmp: begin
                if (i_stat.match) begin
                    if (r_func == ntis_pkg::FnDelete) begin
                        n_state = StDelRd;
                    end else begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.last     = 1'b1;
                        o_cmd.status   = ntis_pkg::StsOk;
                        o_cmd.slot_sel = ntis_pkg::SlotIdx;
                        n_state        = StIdle;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = StScanRd;
                end
            end
            StDelRd: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_last = 1'b1;
                n_state       = StDelWr;
            end
            StDelWr: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_move  = 1'b1;
                o_cmd.cnt_dec  = 1'b1;
                o_cmd.emit     = 1'b1;
                o_cmd.last     = 1'b1;
                o_cmd.status   = ntis_pkg::StsOk;
                o_cmd.slot_sel = ntis_pkg::SlotIdx;
                n_state        = StIdle;
            end
            StListRd: begin
                if (i_stat.empty) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.last     = 1'b1;
                    o_cmd.status   = ntis_pkg::StsEmpty;
                    o_cmd.slot_sel = ntis_pkg::SlotZero;
                    n_state        = StIdle;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = StListOut;
                end
            end
            StListOut: begin
                o_cmd.emit     = 1'b1;
                o_cmd.status   = ntis_pkg::StsOk;
                o_cmd.slot_sel = ntis_pkg::SlotIdx;
                o_cmd.data_sel = 1'b1;
                o_cmd.last     = i_stat.list_last;
                if (i_stat.list_last) begin
                    n_state = StIdle;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = StListRd;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    assign o_busy = (r_state != StIdle);

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_func  <= ntis_pkg::FnCreate;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
        end
    end

endmodule

`default_nettype wire

// ===== design/ntis_dp.sv =====
// ----------------------------------------------------------------------------
// ntis_dp: datapath of the name table core
// Holds the key, the entry count, the walk index, the entry RAM and the
// result register, and reports compare results to the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ntis_dp #(
    parameter int MaxEntries = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [ntis_pkg::HeadW-1:0]   i_key_head,
    input  wire logic [ntis_pkg::TailW-1:0]   i_key_tail,
    input  wire ntis_pkg::t_cmd               i_cmd,
    output      ntis_pkg::t_stat              o_stat,
    output      logic                         o_valid,
    output      logic [ntis_pkg::StatusW-1:0] o_status,
    output      logic [ntis_pkg::SlotW-1:0]   o_slot,
    output      logic [ntis_pkg::HeadW-1:0]   o_entry_head,
    output      logic [ntis_pkg::TailW-1:0]   o_entry_tail,
    output      logic [ntis_pkg::OccW-1:0]    o_occupancy,
    output      logic                         o_last
);

    localparam int AddrW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int CntW  = $clog2(MaxEntries + 1);
    localparam int LimW  = (CntW > ntis_pkg::OccW) ? CntW : ntis_pkg::OccW;

    logic [ntis_pkg::HeadW-1:0]  r_key_head;
    logic [ntis_pkg::TailW-1:0]  r_key_tail;
    logic [CntW-1:0]             r_count, n_count;
    logic [CntW-1:0]             r_idx;
    logic [CntW-1:0]             cnt_m1;
    logic [AddrW-1:0]            rd_addr, wr_addr;
    logic [ntis_pkg::EntryW-1:0] wr_data, rd_data;
    logic [LimW-1:0]             cnt_x, idx_x, list_lim;

    // Hold the key of the item at work
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_head <= i_key_head;
            r_key_tail <= i_key_tail;
        end
    end

    // Update the entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CntW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Walk index over the stored entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CntW'(1);
        end
    end

    // Select RAM addresses and write data
    assign cnt_m1  = r_count - CntW'(1);
    assign rd_addr = i_cmd.rd_last ? cnt_m1[AddrW-1:0] : r_idx[AddrW-1:0];
    assign wr_addr = i_cmd.wr_move ? r_idx[AddrW-1:0] : r_count[AddrW-1:0];
    assign wr_data = i_cmd.wr_move ? rd_data : {r_key_head, r_key_tail};

    ntis_ram #(
        .Width (ntis_pkg::EntryW),
        .Depth (MaxEntries)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Report table state, compare and list end
    assign cnt_x    = LimW'(r_count);
    assign idx_x    = LimW'(r_idx);
    assign list_lim = (cnt_x > LimW'(ntis_pkg::ListCap)) ? LimW'(ntis_pkg::ListCap) : cnt_x;

    assign o_stat.full      = (r_count == CntW'(MaxEntries));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.at_end    = (r_idx == r_count);
    assign o_stat.match     = (rd_data == {r_key_head, r_key_tail});
    assign o_stat.list_last = ((idx_x + LimW'(1)) == list_lim);

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status    <= i_cmd.status;
            o_occupancy <= ntis_pkg::OccW'(n_count);
            o_last      <= i_cmd.last;
            case (i_cmd.slot_sel)
                ntis_pkg::SlotIdx:   o_slot <= ntis_pkg::SlotW'(r_idx);
                ntis_pkg::SlotCount: o_slot <= ntis_pkg::SlotW'(r_count);
                default:             o_slot <= '0;
            endcase
            if (i_cmd.data_sel) begin
                o_entry_head <= rd_data[ntis_pkg::EntryW-1:ntis_pkg::TailW];
                o_entry_tail <= rd_data[ntis_pkg::TailW-1:0];
            end else begin
                o_entry_head <= '0;
                o_entry_tail <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/name_table_insert_delete_search_core.sv =====
// ----------------------------------------------------------------------------
// name_table_insert_delete_search_core: name table with create, delete, search, list
// Create appends the key if there is room. Search and delete read, then compare
// each entry in order to the first match or the count; a matching delete moves
// the last entry into the freed slot. List emits entries in order, at most ListCap
// (empty table: one strobe). One item at a time, busy low again with its final
// strobe. Results cannot be stalled. Reset clears count, control state and valid.
// ----------------------------------------------------------------------------
`default_nettype none

module name_table_insert_delete_search_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [ntis_pkg::FuncW-1:0]   i_func,
    input  wire logic [ntis_pkg::HeadW-1:0]   i_key_head,
    input  wire logic [ntis_pkg::TailW-1:0]   i_key_tail,
    output      logic                         o_valid,
    output      logic [ntis_pkg::StatusW-1:0] o_status,
    output      logic [ntis_pkg::SlotW-1:0]   o_slot,
    output      logic [ntis_pkg::HeadW-1:0]   o_entry_head,
    output      logic [ntis_pkg::TailW-1:0]   o_entry_tail,
    output      logic [ntis_pkg::OccW-1:0]    o_occupancy,
    output      logic                         o_last
);

    ntis_pkg::t_cmd  cmd;
    ntis_pkg::t_stat stat;

    ntis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ntis_dp #(
        .MaxEntries (MAX_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_head   (i_key_head),
        .i_key_tail   (i_key_tail),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_entry_head (o_entry_head),
        .o_entry_tail (o_entry_tail),
        .o_occupancy  (o_occupancy),
        .o_last       (o_last)
    );

    // An accepted item always raises busy in the following cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // The final result of an item leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("busy after final result");

    // Appends only happen into a table with room
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_en && !cmd.wr_move) |-> !stat.full)
        else $error("append into a full table");

    // An empty list result reports no entries and ends the item
    a_empty_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ntis_pkg::StsEmpty)) |-> (o_occupancy == '0) && o_last)
        else $error("empty status with entries or without last mark");

endmodule

`default_nettype wire

// ===== verif/name_table_insert_delete_search_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// name_table_insert_delete_search_core_tb: self-checking bench of the name table
// A short table of directed items covers the empty table, exact 72-bit name
// matches, duplicates, deletes and a full table. Random create, delete, search
// and list traffic follows, with keys mostly from live entries or a name pool.
// A behavioral copy of the table predicts the results of untyped items, and each
// strobed result is compared with the oldest one still waiting.
// ----------------------------------------------------------------------------

module name_table_insert_delete_search_core_tb;

    localparam int TblDepth    = 16;
    localparam int RandItems   = 216;
    localparam int CalmItems   = 40;
    localparam int PhaseItems  = 50;
    localparam int NumDirRows  = 21;
    localparam int DrainCycles = 4000;

    typedef struct packed {
        logic [ntis_pkg::StatusW-1:0] status;
        logic [ntis_pkg::SlotW-1:0]   slot;
        logic [ntis_pkg::HeadW-1:0]   head;
        logic [ntis_pkg::TailW-1:0]   tail;
        logic [ntis_pkg::OccW-1:0]    occ;
        logic                         last;
    } t_name_rslt;

    typedef struct packed {
        logic [ntis_pkg::FuncW-1:0]   fn;
        logic [ntis_pkg::HeadW-1:0]   head;
        logic [ntis_pkg::TailW-1:0]   tail;
        logic [4:0]                   reps;
        logic                         typed;
        logic [ntis_pkg::StatusW-1:0] status;
        logic [ntis_pkg::SlotW-1:0]   slot;
        logic [ntis_pkg::OccW-1:0]    occ;
    } t_dir_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [ntis_pkg::FuncW-1:0]   i_func;
    logic [ntis_pkg::HeadW-1:0]   i_key_head;
    logic [ntis_pkg::TailW-1:0]   i_key_tail;
    logic                         o_valid;
    logic [ntis_pkg::StatusW-1:0] o_status;
    logic [ntis_pkg::SlotW-1:0]   o_slot;
    logic [ntis_pkg::HeadW-1:0]   o_entry_head;
    logic [ntis_pkg::TailW-1:0]   o_entry_tail;
    logic [ntis_pkg::OccW-1:0]    o_occupancy;
    logic                         o_last;

    // Shadow copy of the table
    logic [ntis_pkg::HeadW-1:0]   tbl_head [TblDepth];
    logic [ntis_pkg::TailW-1:0]   tbl_tail [TblDepth];
    int                           tbl_count;

    t_name_rslt                   op_rslts[$];
    t_name_rslt                   pending_rslts[$];
    int                           errors;
    t_dir_row                     dir_rows [NumDirRows];
    logic [ntis_pkg::HeadW-1:0]   name_pool [8];
    logic [ntis_pkg::TailW-1:0]   tail_pool [8];

    name_table_insert_delete_search_core #(
        .MAX_ENTRIES(TblDepth)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_key_head   (i_key_head),
        .i_key_tail   (i_key_tail),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_entry_head (o_entry_head),
        .o_entry_tail (o_entry_tail),
        .o_occupancy  (o_occupancy),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow table and collect its results
    task automatic table_apply(input logic [ntis_pkg::FuncW-1:0] fn,
                               input logic [ntis_pkg::HeadW-1:0] hd,
                               input logic [ntis_pkg::TailW-1:0] tl);
        int         hit;
        int         n;
        t_name_rslt r;
        op_rslts.delete();
        hit = -1;
        for (int k = 0; k < tbl_count; k++) begin
            if (hit < 0 && tbl_head[k] == hd && tbl_tail[k] == tl)
                hit = k;
        end
        r = '0;
        r.last = 1'b1;
        case (fn)
            ntis_pkg::FnCreate: begin
                if (tbl_count >= TblDepth) begin
                    r.status = ntis_pkg::StsFull;
                end else begin
                    tbl_head[tbl_count] = hd;
                    tbl_tail[tbl_count] = tl;
                    r.status = ntis_pkg::StsOk;
                    r.slot = ntis_pkg::SlotW'(tbl_count);
                    tbl_count++;
                end
                r.occ = ntis_pkg::OccW'(tbl_count);
                op_rslts.push_back(r);
            end
            ntis_pkg::FnDelete: begin
                if (hit < 0) begin
                    r.status = ntis_pkg::StsNotFound;
                end else begin
                    // move the last entry into the freed slot
                    tbl_head[hit] = tbl_head[tbl_count-1];
                    tbl_tail[hit] = tbl_tail[tbl_count-1];
                    tbl_count--;
                    r.status = ntis_pkg::StsOk;
                    r.slot = ntis_pkg::SlotW'(hit);
                end
                r.occ = ntis_pkg::OccW'(tbl_count);
                op_rslts.push_back(r);
            end
            ntis_pkg::FnSearch: begin
                if (hit < 0) begin
                    r.status = ntis_pkg::StsNotFound;
                end else begin
                    r.status = ntis_pkg::StsOk;
                    r.slot = ntis_pkg::SlotW'(hit);
                end
                r.occ = ntis_pkg::OccW'(tbl_count);
                op_rslts.push_back(r);
            end
            default: begin
                if (tbl_count == 0) begin
                    r.status = ntis_pkg::StsEmpty;
                    op_rslts.push_back(r);
                end else begin
                    n = (tbl_count > ntis_pkg::ListCap) ? ntis_pkg::ListCap : tbl_count;
                    for (int k = 0; k < n; k++) begin
                        r.status = ntis_pkg::StsOk;
                        r.slot = ntis_pkg::SlotW'(k);
                        r.head = tbl_head[k];
                        r.tail = tbl_tail[k];
                        r.occ = ntis_pkg::OccW'(tbl_count);
                        r.last = (k == n - 1);
                        op_rslts.push_back(r);
                    end
                end
            end
        endcase
    endtask

    // Drive one item from a falling edge, hold it until accepted, queue its results
    task automatic send_item(input logic [ntis_pkg::FuncW-1:0] fn,
                             input logic [ntis_pkg::HeadW-1:0] hd,
                             input logic [ntis_pkg::TailW-1:0] tl, input logic typed,
                             input t_name_rslt typed_rslt);
        start      <= 1'b1;
        i_func     <= fn;
        i_key_head <= hd;
        i_key_tail <= tl;
        do @(posedge i_clk); while (busy);
        table_apply(fn, hd, tl);
        if (typed)
            pending_rslts.push_back(typed_rslt);
        else
            foreach (op_rslts[k]) pending_rslts.push_back(op_rslts[k]);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every queued result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_rslts.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Pick a key: mostly live entries or pool names, some near misses and noise
    task automatic pick_key(output logic [ntis_pkg::HeadW-1:0] hd,
                            output logic [ntis_pkg::TailW-1:0] tl);
        int sel;
        int p;
        int b;
        sel = $urandom_range(0, 99);
        p = $urandom_range(0, 7);
        if (sel < 45 && tbl_count > 0) begin
            p = $urandom_range(0, tbl_count - 1);
            hd = tbl_head[p];
            tl = tbl_tail[p];
        end else if (sel < 75) begin
            hd = name_pool[p];
            tl = tail_pool[p];
        end else if (sel < 88) begin
            hd = name_pool[p];
            tl = tail_pool[p];
            b = $urandom_range(0, ntis_pkg::EntryW - 1);
            if (b < ntis_pkg::HeadW)
                hd[b] = ~hd[b];
            else
                tl[b-ntis_pkg::HeadW] = ~tl[b-ntis_pkg::HeadW];
        end else begin
            hd = {$urandom, $urandom};
            tl = ntis_pkg::TailW'($urandom_range(0, 255));
        end
    endtask

    // Compare each strobed result with the oldest one waiting
    always @(posedge i_clk) begin : rslt_check
        t_name_rslt got;
        t_name_rslt want;
        if (i_rst_n && o_valid) begin
            got = {o_status, o_slot, o_entry_head, o_entry_tail, o_occupancy, o_last};
            if (pending_rslts.size() == 0) begin
                $display("%0t: unexpected result st=%0d slot=%0d head=%h tail=%h occ=%0d",
                         $time, got.status, got.slot, got.head, got.tail, got.occ);
                errors++;
            end else begin
                want = pending_rslts.pop_front();
                if (got !== want) begin
                    $display("%0t: expected st=%0d slot=%0d head=%h tail=%h occ=%0d last=%0b",
                             $time, want.status, want.slot, want.head, want.tail,
                             want.occ, want.last);
                    $display("%0t: actual   st=%0d slot=%0d head=%h tail=%h occ=%0d last=%0b",
                             $time, got.status, got.slot, got.head, got.tail,
                             got.occ, got.last);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("name_table_insert_delete_search_core_tb failed");
        $finish;
    end

    initial begin : stim
        t_name_rslt                 tr;
        logic [ntis_pkg::FuncW-1:0] fn;
        logic [ntis_pkg::HeadW-1:0] hd;
        logic [ntis_pkg::TailW-1:0] tl;
        int                         sel;
        logic                       grow;
        logic                       calm;
        int                         waited;

        errors     = 0;
        tbl_count  = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_func     = ntis_pkg::FnCreate;
        i_key_head = '0;
        i_key_tail = '0;
        foreach (name_pool[k]) begin
            name_pool[k] = {$urandom, $urandom};
            tail_pool[k] = ntis_pkg::TailW'($urandom_range(0, 255));
        end

        // fn, head, tail, reps, typed, status, slot, occupancy
        dir_rows = '{
            '{ntis_pkg::FnList,   64'h0,                   8'h00, 5'd1,  1'b1,
              ntis_pkg::StsEmpty,    4'd0,  5'd0},
            '{ntis_pkg::FnSearch, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 5'd1,  1'b1,
              ntis_pkg::StsNotFound, 4'd0,  5'd0},
            '{ntis_pkg::FnDelete, 64'h0,                   8'h00, 5'd1,  1'b1,
              ntis_pkg::StsNotFound, 4'd0,  5'd0},
            '{ntis_pkg::FnCreate, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd0,  5'd1},
            '{ntis_pkg::FnCreate, 64'h0,                   8'h00, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd1,  5'd2},
            '{ntis_pkg::FnCreate, 64'h4100_4200_0000_0000, 8'h43, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd2,  5'd3},
            '{ntis_pkg::FnCreate, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd3,  5'd4},
            '{ntis_pkg::FnSearch, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFE, 5'd1,  1'b1,
              ntis_pkg::StsNotFound, 4'd0,  5'd4},
            '{ntis_pkg::FnSearch, 64'hFFFF_FFFF_FFFF_FFFE, 8'hFF, 5'd1,  1'b1,
              ntis_pkg::StsNotFound, 4'd0,  5'd4},
            '{ntis_pkg::FnSearch, 64'h4100_4200_0000_0000, 8'h43, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd2,  5'd4},
            '{ntis_pkg::FnSearch, 64'h4100_0000_0000_0000, 8'h43, 5'd1,  1'b1,
              ntis_pkg::StsNotFound, 4'd0,  5'd4},
            '{ntis_pkg::FnList,   64'h0,                   8'h00, 5'd1,  1'b0,
              ntis_pkg::StsOk,       4'd0,  5'd0},
            '{ntis_pkg::FnDelete, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd0,  5'd3},
            '{ntis_pkg::FnSearch, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd0,  5'd3},
            '{ntis_pkg::FnDelete, 64'h4100_4200_0000_0000, 8'h43, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd2,  5'd2},
            '{ntis_pkg::FnCreate, 64'h0123_4567_89AB_CDEF, 8'h5A, 5'd14, 1'b0,
              ntis_pkg::StsOk,       4'd0,  5'd0},
            '{ntis_pkg::FnCreate, 64'h8000_0000_0000_0000, 8'h80, 5'd1,  1'b1,
              ntis_pkg::StsFull,     4'd0,  5'd16},
            '{ntis_pkg::FnList,   64'h0,                   8'h00, 5'd1,  1'b0,
              ntis_pkg::StsOk,       4'd0,  5'd0},
            '{ntis_pkg::FnSearch, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd0,  5'd16},
            '{ntis_pkg::FnDelete, 64'h0123_4567_89AB_CDFC, 8'h5A, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd15, 5'd15},
            '{ntis_pkg::FnDelete, 64'h0,                   8'h00, 5'd1,  1'b1,
              ntis_pkg::StsOk,       4'd1,  5'd14}
        };

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed rows carry their own expected result
        foreach (dir_rows[r]) begin
            for (int rep = 0; rep < dir_rows[r].reps; rep++) begin
                tr = '0;
                tr.status = dir_rows[r].status;
                tr.slot = dir_rows[r].slot;
                tr.occ = dir_rows[r].occ;
                tr.last = 1'b1;
                send_item(dir_rows[r].fn, dir_rows[r].head + ntis_pkg::HeadW'(rep),
                          dir_rows[r].tail, dir_rows[r].typed, tr);
            end
        end

        // Random traffic: alternate fill and drain phases to sweep the occupancy
        tr = '0;
        for (int n = 0; n < RandItems; n++) begin
            grow = ((n / PhaseItems) % 2) == 0;
            calm = (n >= RandItems - CalmItems) || (((n / 30) % 3) == 2);
            if (n == RandItems / 2)
                wait_drained();
            if (!calm && $urandom_range(0, 2) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            sel = $urandom_range(0, 99);
            if (grow)
                fn = (sel < 55) ? ntis_pkg::FnCreate : (sel < 70) ? ntis_pkg::FnDelete :
                     (sel < 90) ? ntis_pkg::FnSearch : ntis_pkg::FnList;
            else
                fn = (sel < 15) ? ntis_pkg::FnCreate : (sel < 65) ? ntis_pkg::FnDelete :
                     (sel < 85) ? ntis_pkg::FnSearch : ntis_pkg::FnList;
            pick_key(hd, tl);
            send_item(fn, hd, tl, 1'b0, tr);
        end
        start <= 1'b0;

        // Drain, then let the block settle
        waited = 0;
        while (pending_rslts.size() != 0 && waited < DrainCycles) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_rslts.size() != 0) begin
            $display("%0t: %0d results missing, expected st=%0d slot=%0d occ=%0d, actual none",
                     $time, pending_rslts.size(), pending_rslts[0].status,
                     pending_rslts[0].slot, pending_rslts[0].occ);
            errors++;
        end

        if (errors == 0)
            $display("name_table_insert_delete_search_core_tb passed");
        else
            $display("name_table_insert_delete_search_core_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/ntis_pkg.sv
design/ntis_ram.sv
design/ntis_ctrl.sv
design/ntis_dp.sv
design/name_table_insert_delete_search_core.sv
verif/name_table_insert_delete_search_core_tb.sv
